@@ hw/rtl/mfp_pkg.sv @@
// types, constants and checksum helpers shared by the frame parser modules
package mfp_pkg;

  localparam logic [7:0] START_V1 = 8'hFE;
  localparam logic [7:0] START_V2 = 8'hFD;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_OK         = 2'd1,
    ST_BAD_CRC    = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic        payload_valid;
    logic [7:0]  payload_index;
    logic [7:0]  payload_data;
    logic [23:0] message_id;
    logic [7:0]  src_system;
    logic [7:0]  src_component;
    logic [7:0]  sequence_res;
    logic [7:0]  payload_length;
    logic        is_v2;
    logic [7:0]  incompat_bits;
    logic [7:0]  compat_bits;
  } result_t;

  // crc-16/mcrf4xx, one byte
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'h000, t[7:4]};
  endfunction

  // per-message extra byte, zero for ids not in the table
  function automatic logic [7:0] extra_for(input logic [23:0] id);
    logic [7:0] v;
    case (id)
      24'd0:   v = 8'd50;
      24'd1:   v = 8'd124;
      24'd2:   v = 8'd137;
      24'd4:   v = 8'd237;
      24'd24:  v = 8'd24;
      24'd30:  v = 8'd39;
      24'd33:  v = 8'd104;
      24'd35:  v = 8'd244;
      24'd36:  v = 8'd54;
      24'd65:  v = 8'd118;
      24'd74:  v = 8'd20;
      24'd76:  v = 8'd152;
      24'd77:  v = 8'd143;
      24'd147: v = 8'd154;
      24'd253: v = 8'd83;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/mfp_parser.sv @@
// frame phase tracking, header capture and checksum for one byte per step
module mfp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output mfp_pkg::result_t res
);
  import mfp_pkg::*;

  typedef enum logic [12:0] {
    PH_IDLE     = 13'h0001,
    PH_LEN      = 13'h0002,
    PH_INCOMPAT = 13'h0004,
    PH_COMPAT   = 13'h0008,
    PH_SEQ      = 13'h0010,
    PH_SYS      = 13'h0020,
    PH_COMP     = 13'h0040,
    PH_ID0      = 13'h0080,
    PH_ID1      = 13'h0100,
    PH_ID2      = 13'h0200,
    PH_PAYLOAD  = 13'h0400,
    PH_CRC1     = 13'h0800,
    PH_CRC2     = 13'h1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ver_r, ver_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [23:0] id_r, id_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  sys_r, sys_nxt;
  logic [7:0]  comp_r, comp_nxt;
  logic [7:0]  incompat_r, incompat_nxt;
  logic [7:0]  compat_r, compat_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [15:0] crc_one;
  logic [23:0] id_full;

  assign crc_one = crc_add(crc_r, rx_byte);

  always_comb begin
    phase_nxt    = phase_r;
    crc_nxt      = crc_r;
    ver_nxt      = ver_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    id_nxt       = id_r;
    seq_nxt      = seq_r;
    sys_nxt      = sys_r;
    comp_nxt     = comp_r;
    incompat_nxt = incompat_r;
    compat_nxt   = compat_r;
    crc_lo_nxt   = crc_lo_r;
    res          = '0;
    id_full      = id_r;

    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == START_V1 || rx_byte == START_V2) begin
          ver_nxt      = (rx_byte == START_V2);
          crc_nxt      = CRC_SEED;
          id_nxt       = '0;
          incompat_nxt = '0;
          compat_nxt   = '0;
          cnt_nxt      = '0;
          phase_nxt    = PH_LEN;
        end
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        crc_nxt   = crc_one;
        phase_nxt = ver_r ? PH_INCOMPAT : PH_SEQ;
      end
      PH_INCOMPAT: begin
        incompat_nxt = rx_byte;
        crc_nxt      = crc_one;
        phase_nxt    = PH_COMPAT;
      end
      PH_COMPAT: begin
        compat_nxt = rx_byte;
        crc_nxt    = crc_one;
        phase_nxt  = PH_SEQ;
      end
      PH_SEQ: begin
        seq_nxt   = rx_byte;
        crc_nxt   = crc_one;
        phase_nxt = PH_SYS;
      end
      PH_SYS: begin
        sys_nxt   = rx_byte;
        crc_nxt   = crc_one;
        phase_nxt = PH_COMP;
      end
      PH_COMP: begin
        comp_nxt  = rx_byte;
        crc_nxt   = crc_one;
        phase_nxt = PH_ID0;
      end
      PH_ID0, PH_ID2: begin
        // first or last id byte for v2, only id byte for v1
        if (phase_r == PH_ID0) begin
          id_full = {16'h0000, rx_byte};
        end else begin
          id_full = {rx_byte, id_r[15:0]};
        end
        id_nxt  = id_full;
        crc_nxt = crc_one;
        if (phase_r == PH_ID0 && ver_r) begin
          phase_nxt = PH_ID1;
        end else begin
          cnt_nxt = '0;
          if (len_r == 8'd0) begin
            // empty payload: extra byte goes in right away
            crc_nxt   = crc_add(crc_one, extra_for(id_full));
            phase_nxt = PH_CRC1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_ID1: begin
        id_nxt    = {8'h00, rx_byte, id_r[7:0]};
        crc_nxt   = crc_one;
        phase_nxt = PH_ID2;
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_index = cnt_r;
        res.payload_data  = rx_byte;
        crc_nxt           = crc_one;
        if ({1'b0, cnt_r} + 9'd1 >= {1'b0, len_r}) begin
          crc_nxt   = crc_add(crc_one, extra_for(id_r));
          phase_nxt = PH_CRC1;
        end
        cnt_nxt = cnt_r + 8'd1;
      end
      PH_CRC1: begin
        crc_lo_nxt = rx_byte;
        phase_nxt  = PH_CRC2;
      end
      PH_CRC2: begin
        res.frame_status   = ({rx_byte, crc_lo_r} == crc_r) ? ST_OK : ST_BAD_CRC;
        res.message_id     = id_r;
        res.src_system     = sys_r;
        res.src_component  = comp_r;
        res.sequence_res   = seq_r;
        res.payload_length = len_r;
        res.is_v2          = ver_r;
        res.incompat_bits  = incompat_r;
        res.compat_bits    = compat_r;
        phase_nxt          = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      crc_r      <= CRC_SEED;
      ver_r      <= 1'b0;
      len_r      <= '0;
      cnt_r      <= '0;
      id_r       <= '0;
      seq_r      <= '0;
      sys_r      <= '0;
      comp_r     <= '0;
      incompat_r <= '0;
      compat_r   <= '0;
      crc_lo_r   <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      crc_r      <= crc_nxt;
      ver_r      <= ver_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      id_r       <= id_nxt;
      seq_r      <= seq_nxt;
      sys_r      <= sys_nxt;
      comp_r     <= comp_nxt;
      incompat_r <= incompat_nxt;
      compat_r   <= compat_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
  end

endmodule

@@ hw/rtl/mavlink_frame_parser_unit.sv @@
// top level of the mavlink v1/v2 frame parser: input register, parser, result register
//
// usage notes
// - input channel (in_valid, in_stall, in_rx_byte): one received serial byte per beat
// - result channel (out_*): exactly one result beat per input beat, in order
//   payload bytes come out with payload_valid, index and data; the beat of the
//   second checksum byte carries frame_status ok or bad crc plus the header
//   fields; every other beat reports incomplete with zeroed fields
// - path: a byte accepted into the input register moves on into the result
//   register when the parser steps; throughput is one byte per cycle while
//   the result side does not stall, set by the single parser step between them
// - stall on the result side holds the result register; the input register
//   still takes a byte while the result waits, and in_stall rises only when
//   both registers are full and out_stall is high
// - reset (rst_n low at a clock edge) empties both registers and puts the
//   parser back to hunting for a start byte with the crc seed loaded
module mavlink_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_index,
  output logic [7:0]  out_payload_data,
  output logic [23:0] out_message_id,
  output logic [7:0]  out_src_system,
  output logic [7:0]  out_src_component,
  output logic [7:0]  out_sequence_res,
  output logic [7:0]  out_payload_length,
  output logic        out_is_v2,
  output logic [7:0]  out_incompat_bits,
  output logic [7:0]  out_compat_bits
);
  import mfp_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // result register
  logic       out_valid_r;
  result_t    out_res_r;

  result_t    res;
  logic       advance;
  logic       in_take;

  // the parser steps when the byte in the input register can move into the
  // result register: that register is empty or being drained this cycle
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  mfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_status   = out_res_r.frame_status;
  assign out_payload_valid  = out_res_r.payload_valid;
  assign out_payload_index  = out_res_r.payload_index;
  assign out_payload_data   = out_res_r.payload_data;
  assign out_message_id     = out_res_r.message_id;
  assign out_src_system     = out_res_r.src_system;
  assign out_src_component  = out_res_r.src_component;
  assign out_sequence_res   = out_res_r.sequence_res;
  assign out_payload_length = out_res_r.payload_length;
  assign out_is_v2          = out_res_r.is_v2;
  assign out_incompat_bits  = out_res_r.incompat_bits;
  assign out_compat_bits    = out_res_r.compat_bits;

`ifndef NO_ASSERTIONS
  // a payload beat never also closes a frame
  a_payload_not_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.payload_valid && out_res_r.frame_status != ST_INCOMPLETE))
    else $error("payload beat carries a frame status");

  // header fields are zero unless a frame completes
  a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.frame_status == ST_INCOMPLETE)
      |-> (out_res_r.message_id == 24'd0 && out_res_r.payload_length == 8'd0
           && out_res_r.is_v2 == 1'b0))
    else $error("header fields set on an incomplete beat");

  // a byte held in the input register stays put while the parser cannot step
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("input register lost or changed a waiting byte");

  // a stalled result beat keeps its status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_res_r.frame_status)))
    else $error("stalled result changed");
`endif

endmodule
